### rtl/core/rid_pkg.sv
// Shared constants and types of the restoring integer divider.
package rid_pkg;

	localparam int DATA_WIDTH = 31;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} rid_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic push;
	} rid_cmd_t;

endpackage

### rtl/core/rid_ctrl.sv
// Controller of the restoring integer divider: sequencing and handshakes.
module rid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rid_pkg::rid_cmd_t cmd
);

	rid_pkg::rid_state_t           state_q, state_d;
	logic [rid_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic                          out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rid_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			rid_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = rid_pkg::CNT_W'(rid_pkg::DATA_WIDTH - 1);
					state_d  = rid_pkg::ST_RUN;
				end
			end
			rid_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = rid_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			rid_pkg::ST_DONE: begin
				// hold until the output slot is free or being emptied
				if (!out_valid_q || out_ready) begin
					cmd.push    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = rid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rid_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/rid_dp.sv
// Datapath of the restoring integer divider: shift-subtract unit and result register.
module rid_dp (
	input  logic                           clk,
	input  rid_pkg::rid_cmd_t              cmd,
	input  logic [rid_pkg::DATA_WIDTH-1:0] dividend,
	input  logic [rid_pkg::DATA_WIDTH-1:0] divisor,
	output logic [rid_pkg::DATA_WIDTH-1:0] quotient,
	output logic [rid_pkg::DATA_WIDTH-1:0] remainder,
	output logic                           divide_by_zero
);

	localparam int W = rid_pkg::DATA_WIDTH;

	logic [W-1:0] rem_q, quo_q, den_q;
	logic         dbz_q;
	logic [W-1:0] quotient_q, remainder_q;
	logic         divide_by_zero_q;
	logic [W:0]   trial, diff;
	logic         fits;

	// bring down the next dividend bit and try the divisor
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = ~diff[W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
			dbz_q <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
		if (cmd.push) begin
			quotient_q       <= dbz_q ? '0 : quo_q;
			remainder_q      <= dbz_q ? '0 : rem_q;
			divide_by_zero_q <= dbz_q;
		end
	end

	assign quotient       = quotient_q;
	assign remainder      = remainder_q;
	assign divide_by_zero = divide_by_zero_q;

endmodule

### rtl/core/restoring_integer_divider_core.sv
// Top level of the restoring integer divider.
// Divides an unsigned 31-bit dividend by an unsigned 31-bit divisor and returns
// the floor quotient and the remainder in one output word. A zero divisor sets
// divide_by_zero and returns quotient and remainder zero. The operands load at
// the accepting edge, 31 shift-subtract steps follow (one quotient bit per cycle
// through a single 32-bit subtractor), then the done state writes the output
// register once the output slot is free or being emptied, and a new word is
// taken in the idle state after that. The block accepts one word at a time;
// in_ready is high whenever the divider is idle, also while a finished word
// still waits in the output register for out_ready.
module restoring_integer_divider_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rid_pkg::DATA_WIDTH-1:0] dividend,
	input  logic [rid_pkg::DATA_WIDTH-1:0] divisor,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rid_pkg::DATA_WIDTH-1:0] quotient,
	output logic [rid_pkg::DATA_WIDTH-1:0] remainder,
	output logic                           divide_by_zero
);

	// commands from the sequencer into the datapath
	rid_pkg::rid_cmd_t cmd;

	rid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// operands load on accept; result register loads on push
	rid_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.dividend       (dividend),
		.divisor        (divisor),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

endmodule

### rtl/core/rid_checker.sv
// Port-level checks of the restoring integer divider and their binding.
module rid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rid_pkg::DATA_WIDTH-1:0] quotient,
	input logic [rid_pkg::DATA_WIDTH-1:0] remainder,
	input logic                           divide_by_zero
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder)
			&& $stable(divide_by_zero))
		else $error("output word changed while stalled");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> quotient == '0 && remainder == '0)
		else $error("divide by zero word carries nonzero result");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new word taken while dividing");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a division in flight");

endmodule

bind restoring_integer_divider_core rid_checker u_rid_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.quotient       (quotient),
	.remainder      (remainder),
	.divide_by_zero (divide_by_zero)
);
